// ===== design/srfr_pkg.sv =====
// Shared constants, register codes and inter-module types for the sync pair row frame receiver.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package srfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int ROWS        = 8;
  localparam int ROW_BYTES   = 2;
  localparam int ROW_DATA_W  = ROW_BYTES * BYTE_W;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

  // Two frame banks: one filling while the other drains
  localparam int NUM_BANKS   = 2;
  localparam int BANK_W      = 1;
  localparam int USE_W       = 2;
  localparam int MEM_ADDR_W  = BANK_W + ROW_W;
  localparam int MEM_DEPTH   = 2 ** MEM_ADDR_W;

  // Frame token queue
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Port field widths
  localparam int ROW_INDEX_W = 3;
  localparam int ROW_BITS_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 2'd1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h55;

  typedef struct packed {
    logic                  en;
    logic [MEM_ADDR_W-1:0] addr;
    logic [ROW_DATA_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic                  en;
    logic [MEM_ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_SHOW = 3'b100
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/srfr_store.sv =====
// Two-bank row store: one write port from the front end, one registered read port to the back end.
// Depends on srfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfr_store (
  input  wire logic                           clk,
  input  wire srfr_pkg::mem_wr_t              wr,
  input  wire srfr_pkg::mem_rd_t              rd,
  output logic [srfr_pkg::ROW_DATA_W-1:0]     rd_data
);

  logic [srfr_pkg::ROW_DATA_W-1:0] mem [srfr_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/srfr_front.sv =====
// Front end: configuration registers, sync pair hunt, row assembly and frame bank writes.
// Depends on srfr_pkg; feeds srfr_store and srfr_queue.
`timescale 1ns / 1ps
`default_nettype none

module srfr_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [srfr_pkg::BYTE_W-1:0]       rx_byte,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [srfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [srfr_pkg::BYTE_W-1:0]       cfg_data,
  output srfr_pkg::mem_wr_t                      wr,
  output logic                                   push_valid,
  output logic [srfr_pkg::BANK_W-1:0]            push_bank,
  input  wire logic                              frame_done
);

  logic [srfr_pkg::BYTE_W-1:0]     sync_first;
  logic [srfr_pkg::BYTE_W-1:0]     sync_second;
  logic                            in_payload;
  logic                            first_sync_seen;
  logic [srfr_pkg::LANE_W-1:0]     lane;
  logic [srfr_pkg::ROW_W-1:0]      row;
  logic [srfr_pkg::BANK_W-1:0]     wr_bank;
  logic [srfr_pkg::USE_W-1:0]      in_use;
  logic [srfr_pkg::USE_W-1:0]      in_use_next;
  logic [srfr_pkg::ROW_DATA_W-1:0] acc;
  logic [srfr_pkg::ROW_DATA_W-1:0] acc_next;
  logic                            accept;
  logic                            lane_last;
  logic                            row_last;
  logic                            frame_end;

  assign cfg_ready = 1'b1;

  // Hold the first payload beat of a frame until a bank is free
  assign in_ready = !(in_payload && (lane == '0) && (row == '0) &&
                      (in_use == srfr_pkg::USE_W'(srfr_pkg::NUM_BANKS)));
  assign accept    = in_valid && in_ready;
  assign lane_last = (lane == srfr_pkg::LANE_W'(srfr_pkg::ROW_BYTES - 1));
  assign row_last  = (row == srfr_pkg::ROW_W'(srfr_pkg::ROWS - 1));
  assign frame_end = accept && in_payload && lane_last && row_last;

  always_comb begin
    acc_next = acc;
    acc_next[lane * srfr_pkg::BYTE_W +: srfr_pkg::BYTE_W] = rx_byte;
  end

  assign wr.en   = accept && in_payload && lane_last;
  assign wr.addr = {wr_bank, row};
  assign wr.data = acc_next;

  assign push_valid = frame_end;
  assign push_bank  = wr_bank;

  always_comb begin
    in_use_next = in_use;
    if (frame_end && !frame_done) begin
      in_use_next = in_use + srfr_pkg::USE_W'(1);
    end else if (!frame_end && frame_done) begin
      in_use_next = in_use - srfr_pkg::USE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= srfr_pkg::SYNC_FIRST_RESET;
      sync_second <= srfr_pkg::SYNC_SECOND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srfr_pkg::CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        srfr_pkg::CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload      <= 1'b0;
      first_sync_seen <= 1'b0;
      lane            <= '0;
      row             <= '0;
      wr_bank         <= '0;
      in_use          <= '0;
    end else begin
      in_use <= in_use_next;
      if (accept) begin
        if (!in_payload) begin
          if (first_sync_seen && (rx_byte == sync_second)) begin
            first_sync_seen <= 1'b0;
            in_payload      <= 1'b1;
            lane            <= '0;
            row             <= '0;
          end else begin
            // re-arm at once when the mismatching beat is itself the first sync byte
            first_sync_seen <= (rx_byte == sync_first);
          end
        end else if (lane_last) begin
          lane <= '0;
          if (row_last) begin
            row        <= '0;
            in_payload <= 1'b0;
            wr_bank    <= wr_bank + srfr_pkg::BANK_W'(1);
          end else begin
            row <= row + srfr_pkg::ROW_W'(1);
          end
        end else begin
          lane <= lane + srfr_pkg::LANE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_payload) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/srfr_queue.sv =====
// Short queue of completed frame bank numbers between front end and back end.
// Depends on srfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfr_queue (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push_valid,
  input  wire logic [srfr_pkg::BANK_W-1:0]    push_bank,
  input  wire logic                           pop,
  output logic                                pop_valid,
  output logic [srfr_pkg::BANK_W-1:0]         pop_bank
);

  logic [srfr_pkg::BANK_W-1:0] slots [srfr_pkg::QDEPTH];
  logic [srfr_pkg::QPTR_W-1:0] wr_ptr;
  logic [srfr_pkg::QPTR_W-1:0] rd_ptr;
  logic [srfr_pkg::QCNT_W-1:0] count;
  logic                        do_pop;

  assign pop_valid = (count != '0);
  assign pop_bank  = slots[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots[wr_ptr] <= push_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= wr_ptr + srfr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + srfr_pkg::QPTR_W'(1);
      end
      if (push_valid && !do_pop) begin
        count <= count + srfr_pkg::QCNT_W'(1);
      end else if (!push_valid && do_pop) begin
        count <= count - srfr_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/srfr_back.sv =====
// Back end: takes a finished frame bank from the queue and shows its rows one per beat.
// Depends on srfr_pkg; reads srfr_store.
`timescale 1ns / 1ps
`default_nettype none

module srfr_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pop_valid,
  input  wire logic [srfr_pkg::BANK_W-1:0]       pop_bank,
  output logic                                   pop,
  output srfr_pkg::mem_rd_t                      rd,
  input  wire logic [srfr_pkg::ROW_DATA_W-1:0]   rd_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [srfr_pkg::ROW_INDEX_W-1:0]       row_index,
  output logic [srfr_pkg::ROW_BITS_W-1:0]        row_bits,
  output logic                                   last_row,
  output logic                                   frame_done
);

  srfr_pkg::back_state_t       state;
  srfr_pkg::back_state_t       state_next;
  logic [srfr_pkg::BANK_W-1:0] bank;
  logic [srfr_pkg::ROW_W-1:0]  row;
  logic                        row_last;

  assign row_last   = (row == srfr_pkg::ROW_W'(srfr_pkg::ROWS - 1));
  assign pop        = (state == srfr_pkg::B_IDLE) && pop_valid;
  assign rd.en      = (state == srfr_pkg::B_READ);
  assign rd.addr    = {bank, row};
  assign out_valid  = (state == srfr_pkg::B_SHOW);
  assign row_index  = srfr_pkg::ROW_INDEX_W'(row);
  assign row_bits   = srfr_pkg::ROW_BITS_W'(rd_data);
  assign last_row   = row_last;
  assign frame_done = out_valid && out_ready && row_last;

  always_comb begin
    state_next = state;
    case (state)
      srfr_pkg::B_IDLE: if (pop_valid) state_next = srfr_pkg::B_READ;
      srfr_pkg::B_READ: state_next = srfr_pkg::B_SHOW;
      srfr_pkg::B_SHOW: begin
        if (out_ready) begin
          state_next = row_last ? srfr_pkg::B_IDLE : srfr_pkg::B_READ;
        end
      end
      default: state_next = srfr_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srfr_pkg::B_IDLE;
      row   <= '0;
      bank  <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        bank <= pop_bank;
        row  <= '0;
      end else if (out_valid && out_ready && !row_last) begin
        row <= row + srfr_pkg::ROW_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sync_pair_row_frame_receiver.sv =====
// Sync pair row frame receiver, top level.
// Input: one byte per cycle; the first payload beat of a frame stalls only while both banks wait.
// Output: after the last payload beat the bank number passes through the queue; each row then
// takes a memory read state and a show state (held until out_ready) in the back end, ROWS rows per frame.
// Synchronous active-high reset: hunting, sync bytes 0xAA/0x55, queue and back end empty.
// Depends on srfr_pkg, srfr_front, srfr_queue, srfr_store, srfr_back.
`timescale 1ns / 1ps
`default_nettype none

module sync_pair_row_frame_receiver (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [srfr_pkg::BYTE_W-1:0]       rx_byte,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [srfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [srfr_pkg::BYTE_W-1:0]       cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [srfr_pkg::ROW_INDEX_W-1:0]       row_index,
  output logic [srfr_pkg::ROW_BITS_W-1:0]        row_bits,
  output logic                                   last_row
);

  srfr_pkg::mem_wr_t               wr;
  srfr_pkg::mem_rd_t               rd;
  logic [srfr_pkg::ROW_DATA_W-1:0] rd_data;
  logic                            push_valid;
  logic [srfr_pkg::BANK_W-1:0]     push_bank;
  logic                            pop;
  logic                            pop_valid;
  logic [srfr_pkg::BANK_W-1:0]     pop_bank;
  logic                            frame_done;

  srfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wr         (wr),
    .push_valid (push_valid),
    .push_bank  (push_bank),
    .frame_done (frame_done)
  );

  srfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_bank  (push_bank),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_bank   (pop_bank)
  );

  srfr_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  srfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_bank   (pop_bank),
    .pop        (pop),
    .rd         (rd),
    .rd_data    (rd_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_index  (row_index),
    .row_bits   (row_bits),
    .last_row   (last_row),
    .frame_done (frame_done)
  );

endmodule

`default_nettype wire

// ===== design/srfr_checker.sv =====
// Port-level checks for the sync pair row frame receiver, bound to the top level.
// Depends on srfr_pkg and sync_pair_row_frame_receiver.
`timescale 1ns / 1ps
`default_nettype none

module srfr_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic [srfr_pkg::ROW_INDEX_W-1:0]  row_index,
  input  wire logic [srfr_pkg::ROW_BITS_W-1:0]   row_bits,
  input  wire logic                              last_row
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_index) && $stable(row_bits)
      && $stable(last_row))
    else $error("output beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_row |-> row_index == srfr_pkg::ROW_INDEX_W'(srfr_pkg::ROWS - 1))
    else $error("final row flagged on wrong row index");

  // Rows of one frame run in order
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_row |=> ##1
      out_valid && row_index == $past(row_index, 2) + srfr_pkg::ROW_INDEX_W'(1))
    else $error("row index did not advance by one");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind sync_pair_row_frame_receiver srfr_checker u_srfr_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .row_index (row_index),
  .row_bits  (row_bits),
  .last_row  (last_row)
);

`default_nettype wire
